// File: hw/rtl/vertex_rotate_project_defines.svh
// Assertion macros shared by the vertex rotate/project RTL.
// No dependencies; included by the top level only.
`ifndef VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define VRP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset
`define VRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// File: hw/rtl/vrp_pkg.sv
// Shared types, constants and the quarter-wave sine table for vertex_rotate_project.
// No dependencies; imported by every module of the block.
package vrp_pkg;

   localparam int ANGLE_BITS = 12;
   localparam int SIN_FRAC   = 14;
   localparam int SIN_ONE    = 1 << SIN_FRAC;
   localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
   localparam int TAB_IDX_W  = ANGLE_BITS - 1;
   localparam int TAB_MAG_W  = SIN_FRAC + 1;
   localparam int SINE_W     = 16;
   localparam int COORD_W    = 16;
   localparam int ROT_W      = 18;
   localparam int DEN_W      = 17;
   localparam int MAG_W      = 29;
   localparam int NUM_W      = 35;
   localparam int DIV_QBITS  = 21;
   localparam int DIV_LAT    = DIV_QBITS + 1;
   localparam int DIV_W      = DEN_W + DIV_QBITS + 2;
   localparam int QUO_W      = DIV_QBITS + 1;
   localparam int OUT_W      = 20;
   localparam int OFF_W      = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register map, byte address = 4 * index
   typedef enum logic [1:0] {
      CSR_SCREEN_WIDTH    = 2'd0,
      CSR_SCREEN_HEIGHT   = 2'd1,
      CSR_FOCAL_LENGTH    = 2'd2,
      CSR_VIEWER_DISTANCE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [11:0]        angle_x;
      logic [11:0]        angle_y;
      logic signed [15:0] vertex_x;
      logic signed [15:0] vertex_y;
      logic signed [15:0] vertex_z;
   } req_word_type;

   typedef struct packed {
      logic signed [19:0] screen_x;
      logic signed [19:0] screen_y;
      logic               behind_viewer;
   } rsp_word_type;

   typedef logic [TAB_MAG_W-1:0] sine_tab_type [0:QUARTER];

   // Odd polynomial in Q2.30 with truncating products, rounded to Q1.14
   function automatic sine_tab_type build_sine_tab();
      sine_tab_type    tab;
      longint unsigned u, u2, p, s, r;
      for (int k = 0; k <= QUARTER; k++) begin
         u  = longint'(k) << (30 - (ANGLE_BITS - 2));
         u2 = (u * u) >> 30;
         p  = 64'd172273;
         p  = 64'd5026995 - ((p * u2) >> 30);
         p  = 64'd85569306 - ((p * u2) >> 30);
         p  = 64'd693598669 - ((p * u2) >> 30);
         p  = 64'd1686629713 - ((p * u2) >> 30);
         s  = (p * u) >> 30;
         r  = (s + 64'd32768) >> 16;
         tab[k] = (r > longint'(SIN_ONE)) ? TAB_MAG_W'(SIN_ONE) : r[TAB_MAG_W-1:0];
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage

// File: hw/rtl/vrp_sine_rom.sv
// Registered sine lookup: quarter-wave ROM plus quadrant folding.
// Depends on vrp_pkg for the table and angle widths.
module vrp_sine_rom import vrp_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic [ANGLE_BITS-1:0]    angle,
   output logic signed [SINE_W-1:0] sine
);

   logic [1:0]            quad;
   logic [TAB_IDX_W-1:0]  idx;
   logic [TAB_MAG_W-1:0]  mag_ff;
   logic                  neg_ff;

   // Fold the angle into the first quadrant
   assign quad = angle[ANGLE_BITS-1:ANGLE_BITS-2];
   always_comb begin
      if (quad[0]) begin
         idx = TAB_IDX_W'(QUARTER) - {1'b0, angle[ANGLE_BITS-3:0]};
      end else begin
         idx = {1'b0, angle[ANGLE_BITS-3:0]};
      end
   end

   // Read the table, hold on stall
   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= SINE_TAB[idx];
         neg_ff <= quad[1];
      end
   end

   // Apply the lower half-turn sign
   always_comb begin
      if (neg_ff) begin
         sine = -$signed(SINE_W'(mag_ff));
      end else begin
         sine = $signed(SINE_W'(mag_ff));
      end
   end

endmodule

// File: hw/rtl/vrp_rotate.sv
// Two-stage planar rotation: products, then sums rounded from Q1.14.
// Depends on vrp_pkg for widths.
module vrp_rotate import vrp_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [SINE_W-1:0] sin_val,
   input  logic signed [SINE_W-1:0] cos_val,
   input  logic signed [ROT_W-1:0]  a,
   input  logic signed [ROT_W-1:0]  b,
   output logic signed [ROT_W-1:0]  r_diff,
   output logic signed [ROT_W-1:0]  r_sum
);

   localparam int PROD_W = SINE_W + ROT_W;
   localparam int SUM_W  = PROD_W + 1;

   logic signed [PROD_W-1:0] ca_ff, sb_ff, sa_ff, cb_ff;
   logic signed [SUM_W-1:0]  diff, sum;
   logic signed [ROT_W-1:0]  r_diff_in, r_sum_in;
   logic signed [ROT_W-1:0]  r_diff_ff, r_sum_ff;

   // Round to nearest, ties away from zero
   function automatic logic signed [ROT_W-1:0] round_q14(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0] mag;
      logic [SUM_W-1:0] rnd;
      mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
      rnd = (mag + SUM_W'(1 << (SIN_FRAC - 1))) >> SIN_FRAC;
      return v[SUM_W-1] ? -$signed(rnd[ROT_W-1:0]) : $signed(rnd[ROT_W-1:0]);
   endfunction

   // Stage one: four products
   always_ff @(posedge clock) begin
      if (en) begin
         ca_ff <= cos_val * a;
         sb_ff <= sin_val * b;
         sa_ff <= sin_val * a;
         cb_ff <= cos_val * b;
      end
   end

   // Stage two: combine and round
   assign diff      = SUM_W'(ca_ff) - SUM_W'(sb_ff);
   assign sum       = SUM_W'(sa_ff) + SUM_W'(cb_ff);
   assign r_diff_in = round_q14(diff);
   assign r_sum_in  = round_q14(sum);

   always_ff @(posedge clock) begin
      if (en) begin
         r_diff_ff <= r_diff_in;
         r_sum_ff  <= r_sum_in;
      end
   end

   assign r_diff = r_diff_ff;
   assign r_sum  = r_sum_ff;

endmodule

// File: hw/rtl/vrp_divider.sv
// Pipelined restoring divider: rounded signed quotient, one bit per stage.
// Depends on vrp_pkg for widths and stage count.
module vrp_divider import vrp_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic [MAG_W-1:0]        mag,
   input  logic                    neg,
   input  logic [DEN_W-1:0]        den,
   output logic signed [QUO_W-1:0] quotient
);

   logic [NUM_W-1:0]     num;
   logic [DEN_W:0]       dv;
   logic [NUM_W-1:0]     rem_ff [0:DIV_QBITS];
   logic [DIV_QBITS-1:0] quo_ff [0:DIV_QBITS];
   logic [DEN_W:0]       dv_ff  [0:DIV_QBITS];
   logic                 neg_ff [0:DIV_QBITS];
   logic                 ovf_ff [0:DIV_QBITS];
   logic [DIV_QBITS-1:0] quo_mag;

   // round(m*16/d) = floor((32m + d) / 2d)
   assign num = NUM_W'({mag, 5'b0}) + NUM_W'(den);
   assign dv  = {den, 1'b0};

   // Entry stage: flag quotients too large to matter before saturation
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num;
         quo_ff[0] <= '0;
         dv_ff[0]  <= dv;
         neg_ff[0] <= neg;
         ovf_ff[0] <= DIV_W'(num) >= (DIV_W'(dv) << DIV_QBITS);
      end
   end

   // One quotient bit per stage, most significant first
   for (genvar j = 1; j <= DIV_QBITS; j++) begin : g_stage
      localparam int B = DIV_QBITS - j;
      logic [DIV_W-1:0]     shifted;
      logic                 ge;
      logic [NUM_W-1:0]     rem_in;
      logic [DIV_QBITS-1:0] quo_in;

      always_comb begin
         shifted = DIV_W'(dv_ff[j-1]) << B;
         ge      = DIV_W'(rem_ff[j-1]) >= shifted;
         rem_in  = ge ? NUM_W'(DIV_W'(rem_ff[j-1]) - shifted) : rem_ff[j-1];
         quo_in    = quo_ff[j-1];
         quo_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
            dv_ff[j]  <= dv_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   // Clamp and restore sign
   assign quo_mag = ovf_ff[DIV_QBITS] ? '1 : quo_ff[DIV_QBITS];
   always_comb begin
      if (neg_ff[DIV_QBITS]) begin
         quotient = -$signed({1'b0, quo_mag});
      end else begin
         quotient = $signed({1'b0, quo_mag});
      end
   end

endmodule

// File: hw/rtl/vertex_rotate_project.sv
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the response register is full and not taken.
// Reset clears the valid bits and loads the CSR registers with their defaults.
// Stages: sine ROM, two rotation pairs, perspective multiply, 22-stage divider.
module vertex_rotate_project
   import vrp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

`include "vertex_rotate_project_defines.svh"

   logic [12:0] width_ff, height_ff;
   logic [11:0] focal_ff;
   logic [14:0] dist_ff;
   logic        csr_write;
   csr_index_type csr_idx;

   logic en;

   logic signed [SINE_W-1:0]  sin_x, cos_x, sin_y, cos_y;
   logic [ANGLE_BITS-1:0]     cos_ang_x, cos_ang_y;
   logic                      v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic signed [COORD_W-1:0] x1_ff, y1c_ff, z1c_ff, x2_ff, x3_ff;
   logic signed [SINE_W-1:0]  sy2_ff, cy2_ff, sy3_ff, cy3_ff;
   logic signed [ROT_W-1:0]   rx_y, rx_z, ry_z, ry_x;
   logic signed [ROT_W-1:0]   y4_ff, y5_ff;

   logic signed [ROT_W:0]     depth;
   logic                      behind;
   logic [ROT_W-1:0]          abs_x, abs_y;
   logic [MAG_W-1:0]          mx_ff, my_ff;
   logic                      nx_ff, ny_ff, behind6_ff;
   logic [DEN_W-1:0]          den_ff;

   logic                      valid_pipe_ff  [0:DIV_LAT-1];
   logic                      behind_pipe_ff [0:DIV_LAT-1];
   logic signed [QUO_W-1:0]   qx, qy;

   logic [OFF_W-1:0]          off_x, off_y;
   rsp_word_type              rsp_in;
   rsp_word_type              rsp_ff;
   logic                      rsp_valid_ff;

   // Saturate a biased quotient to the 20-bit output range
   function automatic logic signed [OUT_W-1:0] place(input logic signed [QUO_W-1:0] q,
                                                     input logic [OFF_W-1:0] off);
      logic signed [QUO_W+1:0] s;
      s = (QUO_W+2)'(q) + (QUO_W+2)'($signed({1'b0, off}));
      if (s > (QUO_W+2)'((1 << (OUT_W - 1)) - 1)) begin
         return OUT_W'((1 << (OUT_W - 1)) - 1);
      end else if (s < -(QUO_W+2)'(1 << (OUT_W - 1))) begin
         return OUT_W'(-(1 << (OUT_W - 1)));
      end else begin
         return s[OUT_W-1:0];
      end
   endfunction

   // Register file writes
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd800;
         height_ff <= 13'd800;
         focal_ff  <= 12'd256;
         dist_ff   <= 15'd16384;
      end else if (csr_write) begin
         case (csr_idx)
            CSR_SCREEN_WIDTH:    width_ff  <= csr_pwdata[12:0];
            CSR_SCREEN_HEIGHT:   height_ff <= csr_pwdata[12:0];
            CSR_FOCAL_LENGTH:    focal_ff  <= csr_pwdata[11:0];
            CSR_VIEWER_DISTANCE: dist_ff   <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   // Register file reads
   always_comb begin
      case (csr_idx)
         CSR_SCREEN_WIDTH:    csr_prdata = CSR_DATA_W'(width_ff);
         CSR_SCREEN_HEIGHT:   csr_prdata = CSR_DATA_W'(height_ff);
         CSR_FOCAL_LENGTH:    csr_prdata = CSR_DATA_W'(focal_ff);
         CSR_VIEWER_DISTANCE: csr_prdata = CSR_DATA_W'(dist_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // Advance everything unless the response word is stuck
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // Stage 1: sine and cosine lookups
   assign cos_ang_x = req_data.angle_x[ANGLE_BITS-1:0] + ANGLE_BITS'(QUARTER);
   assign cos_ang_y = req_data.angle_y[ANGLE_BITS-1:0] + ANGLE_BITS'(QUARTER);

   vrp_sine_rom u_sin_x (.clock, .en, .angle(req_data.angle_x[ANGLE_BITS-1:0]), .sine(sin_x));
   vrp_sine_rom u_cos_x (.clock, .en, .angle(cos_ang_x), .sine(cos_x));
   vrp_sine_rom u_sin_y (.clock, .en, .angle(req_data.angle_y[ANGLE_BITS-1:0]), .sine(sin_y));
   vrp_sine_rom u_cos_y (.clock, .en, .angle(cos_ang_y), .sine(cos_y));

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff  <= req_data.vertex_x;
         y1c_ff <= req_data.vertex_y;
         z1c_ff <= req_data.vertex_z;
      end
   end

   // Stages 2-3: rotate about X, carry Y-axis terms alongside
   vrp_rotate u_rot_x (
      .clock, .en,
      .sin_val(sin_x), .cos_val(cos_x),
      .a(ROT_W'(y1c_ff)), .b(ROT_W'(z1c_ff)),
      .r_diff(rx_y), .r_sum(rx_z)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sy2_ff <= sin_y;
         cy2_ff <= cos_y;
         x2_ff  <= x1_ff;
         sy3_ff <= sy2_ff;
         cy3_ff <= cy2_ff;
         x3_ff  <= x2_ff;
      end
   end

   // Stages 4-5: rotate about Y, delay rotated y
   vrp_rotate u_rot_y (
      .clock, .en,
      .sin_val(sy3_ff), .cos_val(cy3_ff),
      .a(rx_z), .b(ROT_W'(x3_ff)),
      .r_diff(ry_z), .r_sum(ry_x)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         y4_ff <= rx_y;
         y5_ff <= y4_ff;
      end
   end

   // Stage 6: depth test and numerator products
   assign depth  = $signed({4'b0, dist_ff}) - (ROT_W+1)'(ry_z);
   assign behind = depth[ROT_W] || (depth == '0);
   assign abs_x  = ry_x[ROT_W-1] ? ROT_W'(-ry_x) : ROT_W'(ry_x);
   assign abs_y  = y5_ff[ROT_W-1] ? ROT_W'(-y5_ff) : ROT_W'(y5_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff      <= MAG_W'(abs_x[DEN_W-1:0]) * MAG_W'(focal_ff);
         my_ff      <= MAG_W'(abs_y[DEN_W-1:0]) * MAG_W'(focal_ff);
         nx_ff      <= ry_x[ROT_W-1];
         ny_ff      <= y5_ff[ROT_W-1];
         den_ff     <= behind ? DEN_W'(1) : depth[DEN_W-1:0];
         behind6_ff <= behind;
      end
   end

   // Stages 7-28: perspective divide
   vrp_divider u_div_x (.clock, .en, .mag(mx_ff), .neg(nx_ff), .den(den_ff), .quotient(qx));
   vrp_divider u_div_y (.clock, .en, .mag(my_ff), .neg(ny_ff), .den(den_ff), .quotient(qy));

   always_ff @(posedge clock) begin
      if (en) begin
         behind_pipe_ff[0] <= behind6_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            behind_pipe_ff[i] <= behind_pipe_ff[i-1];
         end
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         for (int i = 0; i < DIV_LAT; i++) begin
            valid_pipe_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         valid_pipe_ff[0] <= v6_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            valid_pipe_ff[i] <= valid_pipe_ff[i-1];
         end
         rsp_valid_ff <= valid_pipe_ff[DIV_LAT-1];
      end
   end

   // Stage 29: add screen centre, saturate, register response word
   assign off_x = {width_ff, 3'b0};
   assign off_y = {height_ff, 3'b0};

   always_comb begin
      if (behind_pipe_ff[DIV_LAT-1]) begin
         rsp_in.screen_x = OUT_W'(off_x);
         rsp_in.screen_y = OUT_W'(off_y);
      end else begin
         rsp_in.screen_x = place(qx, off_x);
         rsp_in.screen_y = place(qy, off_y);
      end
      rsp_in.behind_viewer = behind_pipe_ff[DIV_LAT-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `VRP_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, v1_ff)
   `VRP_ASSERT_NEXT(a_stall_holds, clock, reset, !en, $stable(v6_ff) && $stable(rsp_ff))
   `VRP_ASSERT_IMPL(a_behind_centre, clock, reset, rsp_valid && rsp_data.behind_viewer,
                    rsp_data.screen_x == OUT_W'(off_x) && rsp_data.screen_y == OUT_W'(off_y))

endmodule
